// ----- hdl/lrr_pkg.sv -----
// Shared types and constants for the linked row range removal block.
`default_nettype none
package lrr_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int LINK_W      = 11;
  localparam int SIZE_W      = 11;
  localparam int SIZE_RESET  = 1024;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_REMOVE  = 1'b1;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LINK  = 3'b100
  } state_t;

  typedef struct packed {
    logic busy;
    logic last;
  } sweep_status_t;

endpackage
`default_nettype wire

// ----- hdl/lrr_link_mem.sv -----
// One link memory: one write port, one read port, registered read data.
`default_nettype none
module lrr_link_mem #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire lrr_pkg::link_t  wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output lrr_pkg::link_t       rdata
);
  import lrr_pkg::*;

  link_t mem [DEPTH];
  link_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/lrr_sweep.sv -----
// Relink sweep: walks entries 1..MAX_ENTRIES and builds the link values.
`default_nettype none
module lrr_sweep #(
  parameter int MAX_ENTRIES = 1024,
  parameter int AW          = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire lrr_pkg::size_t         size_in,
  output logic [AW-1:0]               addr,
  output lrr_pkg::link_t              prev_data,
  output lrr_pkg::link_t              next_data,
  output lrr_pkg::sweep_status_t      status
);
  import lrr_pkg::*;

  localparam int CW          = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int SizeRstInt  = (SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : SIZE_RESET;
  localparam size_t SizeRst  = SIZE_W'(SizeRstInt);
  localparam logic [AW-1:0] LastIdx = AW'(MAX_ENTRIES);

  logic          busy_r;
  logic [AW-1:0] cnt_r;
  size_t         size_r;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] size_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= AW'(1);
      size_r <= SizeRst;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= AW'(1);
      size_r <= size_in;
    end else if (busy_r) begin
      if (cnt_r == LastIdx) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  assign cnt_ext  = CW'(cnt_r);
  assign size_ext = CW'(size_r);

  // entries past the row size are cleared to "none"
  assign prev_data   = (cnt_ext <= size_ext) ? LINK_W'(cnt_r - AW'(1)) : '0;
  assign next_data   = (cnt_ext <  size_ext) ? LINK_W'(cnt_r + AW'(1)) : '0;
  assign addr        = cnt_r;
  assign status.busy = busy_r;
  assign status.last = busy_r && (cnt_r == LastIdx);

endmodule
`default_nettype wire

// ----- hdl/linked_row_range_removal_unit.sv -----
// Top level of the linked row range removal block.
`default_nettype none
// Keeps entries 1..size as a doubly linked list in two link memories
// (previous and next, MAX_ENTRIES+1 words of 11 bits each, one write and one
// registered read port apiece). A remove word reads previous[first] and
// next[last] in its accept cycle; the link state then, once the result
// register is free, writes the two joined links and loads the result
// register; that read-then-write through the memory ports sets the rate.
// An accepted restart word sweeps every entry, one per cycle; no result is
// produced. After reset the same sweep runs (with in_ready low) to build
// the initial row; cfg writes are taken at any time.
// A rejected run (first 0, last past the size, or first after last) returns
// a word with bad_request set and all other fields 0, links untouched.
// The result register lets a new word be accepted while one waits.
module linked_row_range_removal_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // configuration: row size, clamped to 1..MAX_ENTRIES
  input  wire logic            cfg_we,
  input  wire lrr_pkg::size_t  cfg_wdata,
  // input channel
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_op,
  input  wire lrr_pkg::link_t  in_first_gone,
  input  wire lrr_pkg::link_t  in_last_gone,
  // result channel
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lrr_pkg::link_t       out_left_survivor,
  output logic                 out_left_none,
  output lrr_pkg::link_t       out_right_survivor,
  output logic                 out_right_none,
  output logic                 out_bad_request
);
  import lrr_pkg::*;

  localparam int AW         = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH      = MAX_ENTRIES + 1;
  localparam int CW         = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int SizeRstInt = (SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : SIZE_RESET;
  localparam size_t SizeRst = SIZE_W'(SizeRstInt);
  localparam logic [CW-1:0] MaxExt = CW'(MAX_ENTRIES);

  state_t        state_r, state_nxt;
  size_t         size_r;
  logic          bad_r;

  logic          out_valid_r;
  link_t         out_left_r;
  logic          out_left_none_r;
  link_t         out_right_r;
  logic          out_right_none_r;
  logic          out_bad_r;

  logic          in_accept;
  logic          bad_now;
  logic          sweep_start;
  logic          slot_free;
  logic          commit;

  link_t         rd_prev, rd_next;
  link_t         left_link, right_link;

  logic [AW-1:0]  sw_addr;
  link_t          sw_prev, sw_next;
  sweep_status_t  sw_stat;

  logic           prev_we, next_we;
  logic [AW-1:0]  prev_waddr, next_waddr;
  link_t          prev_wdata, next_wdata;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SizeRst;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        size_r <= SIZE_W'(1);
      end else if (CW'(cfg_wdata) > MaxExt) begin
        size_r <= SIZE_W'(MAX_ENTRIES);
      end else begin
        size_r <= cfg_wdata;
      end
    end
  end

  // ---------------------------------------------------------------- control
  assign in_ready    = (state_r == ST_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign sweep_start = in_accept && (in_op == OP_RESTART);
  assign bad_now     = (in_first_gone == '0) || (in_last_gone > size_r) ||
                       (in_first_gone > in_last_gone);
  assign slot_free   = !out_valid_r || out_ready;
  assign commit      = (state_r == ST_LINK) && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sw_stat.last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_nxt = (in_op == OP_RESTART) ? ST_SWEEP : ST_LINK;
      end
      ST_LINK: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      bad_r <= bad_now;
    end
  end

  // ---------------------------------------------------------------- memories
  // Links never exceed MAX_ENTRIES; the range check keeps the join write addresses in range.
  assign left_link  = (CW'(rd_prev) > MaxExt) ? '0 : rd_prev;
  assign right_link = (CW'(rd_next) > MaxExt) ? '0 : rd_next;

  always_comb begin
    if (sw_stat.busy) begin
      prev_we    = 1'b1;
      prev_waddr = sw_addr;
      prev_wdata = sw_prev;
      next_we    = 1'b1;
      next_waddr = sw_addr;
      next_wdata = sw_next;
    end else begin
      // join: previous[right] = left, next[left] = right
      prev_we    = commit && !bad_r && (right_link != '0);
      prev_waddr = AW'(right_link);
      prev_wdata = left_link;
      next_we    = commit && !bad_r && (left_link != '0);
      next_waddr = AW'(left_link);
      next_wdata = right_link;
    end
  end

  lrr_link_mem #(.DEPTH(DEPTH), .AW(AW)) u_prev_mem (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (in_accept),
    .raddr (AW'(in_first_gone)),
    .rdata (rd_prev)
  );

  lrr_link_mem #(.DEPTH(DEPTH), .AW(AW)) u_next_mem (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (in_accept),
    .raddr (AW'(in_last_gone)),
    .rdata (rd_next)
  );

  lrr_sweep #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW)) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sweep_start),
    .size_in   (size_r),
    .addr      (sw_addr),
    .prev_data (sw_prev),
    .next_data (sw_next),
    .status    (sw_stat)
  );

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_bad_r        <= bad_r;
      out_left_r       <= bad_r ? '0 : left_link;
      out_left_none_r  <= !bad_r && (left_link == '0);
      out_right_r      <= bad_r ? '0 : right_link;
      out_right_none_r <= !bad_r && (right_link == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_survivor  = out_left_r;
  assign out_left_none      = out_left_none_r;
  assign out_right_survivor = out_right_r;
  assign out_right_none     = out_right_none_r;
  assign out_bad_request    = out_bad_r;

  // ---------------------------------------------------------------- checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sw_stat.busy |-> !in_ready)
    else $error("word accepted while the link sweep runs");

  a_restart_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_start |=> sw_stat.busy)
    else $error("restart did not start the sweep");

  a_result_from_link: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LINK))
    else $error("result loaded outside the link step");

  a_link_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE))
    else $error("link step did not finish after commit");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the linked row range removal unit.
module tb;
  import lrr_pkg::*;

  localparam int FIELD_MAX   = 2047;   // all ones in an 11-bit field
  localparam int SWEEP_WAIT  = 1200;   // covers the restart sweep over all MAX_ENTRIES entries
  localparam int STALL_LIMIT = 20000;  // cycles with no word moving on either side

  typedef struct packed {
    logic  op;
    link_t first;
    link_t last;
  } removal_req_t;

  typedef struct packed {
    link_t left;
    logic  left_none;
    link_t right;
    logic  right_none;
    logic  bad;
  } survivors_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  size_t cfg_wdata = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  in_op = OP_RESTART;
  link_t in_first_gone = '0;
  link_t in_last_gone = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  link_t out_left_survivor;
  logic  out_left_none;
  link_t out_right_survivor;
  logic  out_right_none;
  logic  out_bad_request;

  linked_row_range_removal_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_first_gone(in_first_gone), .in_last_gone(in_last_gone),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_survivor(out_left_survivor), .out_left_none(out_left_none),
    .out_right_survivor(out_right_survivor), .out_right_none(out_right_none),
    .out_bad_request(out_bad_request)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the row: both link memories and the clamped size.
  link_t        prev_of [0:MAX_ENTRIES];
  link_t        next_of [0:MAX_ENTRIES];
  int           row_size;

  // Stimulus side only: which entries the generator believes are still linked.
  bit           alive [0:MAX_ENTRIES];

  removal_req_t request_q [$];
  survivors_t   survivor_q [$];
  removal_req_t next_word;
  survivors_t   got, want;
  bit           idle_on = 1'b1;
  int           gap_left = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;
  int           errors = 0;

  function automatic int clamp_size(size_t v);
    if (v == 0) return 1;
    if (v > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(v);
  endfunction

  function automatic void relink_row();
    for (int i = 0; i <= MAX_ENTRIES; i++) begin
      prev_of[i] = '0;
      next_of[i] = '0;
      if (i >= 1 && i <= row_size) begin
        prev_of[i] = link_t'(i - 1);
        next_of[i] = (i < row_size) ? link_t'(i + 1) : '0;
      end
    end
  endfunction

  // Applies one accepted word to the shadow row; a removal queues its report.
  function automatic void unlink_and_report(logic op, link_t first, link_t last);
    survivors_t r;
    link_t      lft, rgt;
    r = '0;
    if (op == OP_RESTART) begin
      relink_row();
    end else if (first == 0 || last > row_size || first > last) begin
      r.bad = 1'b1;
      survivor_q = {survivor_q, r};
    end else begin
      lft = (prev_of[first] > MAX_ENTRIES) ? '0 : prev_of[first];
      rgt = (next_of[last] > MAX_ENTRIES) ? '0 : next_of[last];
      // joins skip the "none" end of the list
      if (rgt != 0) prev_of[rgt] = lft;
      if (lft != 0) next_of[lft] = rgt;
      r.left       = lft;
      r.left_none  = (lft == 0);
      r.right      = rgt;
      r.right_none = (rgt == 0);
      survivor_q = {survivor_q, r};
    end
  endfunction

  task automatic push_word(logic op, int a, int b);
    removal_req_t w;
    w.op    = op;
    w.first = link_t'(a);
    w.last  = link_t'(b);
    request_q = {request_q, w};
  endtask

  // Restart fields are don't-care, so they carry random bits.
  task automatic queue_restart();
    push_word(OP_RESTART, $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
    for (int i = 0; i <= MAX_ENTRIES; i++) alive[i] = (i >= 1 && i <= row_size);
  endtask

  // Well-formed removal: a run of up to span entries that are still linked, or a restart when none is left.
  task automatic queue_run(int span);
    int a, b, left;
    a = $urandom_range(1, row_size);
    while (a <= row_size && !alive[a]) a++;
    if (a > row_size) begin
      a = 1;
      while (a <= row_size && !alive[a]) a++;
    end
    if (a > row_size) begin
      queue_restart();
    end else begin
      b = a;
      left = span - 1;
      alive[a] = 1'b0;
      for (int j = a + 1; j <= row_size && left > 0; j++) begin
        if (alive[j]) begin
          alive[j] = 1'b0;
          b = j;
          left--;
        end
      end
      push_word(OP_REMOVE, a, b);
    end
  endtask

  // Rejected runs, random fields and stale in-range runs.
  task automatic queue_noise();
    int b;
    case ($urandom_range(0, 4))
      0: push_word(OP_REMOVE, 0, $urandom_range(0, FIELD_MAX));
      1: push_word(OP_REMOVE, $urandom_range(1, row_size),
                   $urandom_range(row_size + 1, FIELD_MAX));
      2: begin
        b = $urandom_range(1, row_size);
        push_word(OP_REMOVE, $urandom_range(b + 1, FIELD_MAX), b);
      end
      3: push_word(OP_REMOVE, $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
      default: begin
        b = $urandom_range(1, row_size);
        push_word(OP_REMOVE, $urandom_range(1, b), b);
      end
    endcase
  endtask

  task automatic queue_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) queue_restart();
    else if (r < 74) queue_run(($urandom_range(0, 4) != 0) ? $urandom_range(1, 3)
                                                             : $urandom_range(1, row_size));
    else queue_noise();
  endtask

  // Sampled on the falling edge so the driver and monitor have settled.
  task automatic drain();
    while (request_q.size() != 0 || in_valid || survivor_q.size() != 0) @(negedge clk);
    // a restart makes no report, so give its sweep time to finish
    repeat (SWEEP_WAIT) @(posedge clk);
  endtask

  task automatic set_row_size(size_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    row_size = clamp_size(v);
  endtask

  // Driver: presents queued words, with random idle bursts between them while idle_on is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) unlink_and_report(in_op, in_first_gone, in_last_gone);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 17);
        end else if (request_q.size() != 0) begin
          next_word = request_q.pop_front();
          in_valid      <= 1'b1;
          in_op         <= next_word.op;
          in_first_gone <= next_word.first;
          in_last_gone  <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each report against the oldest expectation; stalls at random while idle_on is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.left       = out_left_survivor;
        got.left_none  = out_left_none;
        got.right      = out_right_survivor;
        got.right_none = out_right_none;
        got.bad        = out_bad_request;
        if (survivor_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: left %0d/%0b right %0d/%0b bad %0b",
                     got.left, got.left_none, got.right, got.right_none, got.bad);
        end else begin
          want = survivor_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: got left %0d/%0b right %0d/%0b bad %0b, %s %0d/%0b %0d/%0b %0b",
                       got.left, got.left_none, got.right, got.right_none, got.bad,
                       "want", want.left, want.left_none, want.right, want.right_none,
                       want.bad);
          end
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles where no word moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_size = SIZE_RESET;
    relink_row();
    for (int i = 0; i <= MAX_ENTRIES; i++) alive[i] = (i >= 1);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset row of 1024: both ends, an inner run, rejected runs, stale runs, then a restart and a full-row removal.
    push_word(OP_REMOVE, 1, 1);
    push_word(OP_REMOVE, 1024, 1024);
    push_word(OP_REMOVE, 5, 9);
    push_word(OP_REMOVE, 4, 10);
    push_word(OP_REMOVE, 0, 0);
    push_word(OP_REMOVE, 0, FIELD_MAX);
    push_word(OP_REMOVE, 3, 1025);
    push_word(OP_REMOVE, 9, 8);
    push_word(OP_REMOVE, FIELD_MAX, FIELD_MAX);
    push_word(OP_REMOVE, 1024, 1024);
    push_word(OP_RESTART, FIELD_MAX, 0);
    push_word(OP_REMOVE, 1, 1024);
    drain();

    // Shrink without restart: links still name entries past the new size.
    set_row_size(5);
    push_word(OP_REMOVE, 5, 5);
    push_word(OP_REMOVE, 1, 5);
    drain();

    // Size 0 is taken as 1.
    set_row_size(0);
    push_word(OP_RESTART, 0, 0);
    push_word(OP_REMOVE, 1, 1);
    push_word(OP_REMOVE, 1, 2);
    drain();

    // Oversize is taken as MAX_ENTRIES.
    set_row_size(FIELD_MAX);
    push_word(OP_RESTART, 0, 0);
    push_word(OP_REMOVE, 1024, 1024);
    push_word(OP_REMOVE, 2, 1023);
    drain();

    set_row_size(2);
    push_word(OP_RESTART, 0, 0);
    push_word(OP_REMOVE, 2, 2);
    push_word(OP_REMOVE, 1, 1);
    drain();

    // Random phases, each with its own size; a few skip the restart.
    for (int p = 0; p < 8; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0: set_row_size(0);
        1: set_row_size(FIELD_MAX);
        2: set_row_size(1);
        3: set_row_size(2);
        4: set_row_size(size_t'($urandom_range(3, 16)));
        5: set_row_size(size_t'($urandom_range(17, 128)));
        6: set_row_size(size_t'($urandom_range(1, MAX_ENTRIES)));
        default: set_row_size(MAX_ENTRIES);
      endcase
      if ($urandom_range(0, 4) != 0) queue_restart();
      for (int k = 0; k < 60; k++) queue_random();
      drain();
    end

    // Closing phase at full size, no idling on either side.
    idle_on = 1'b0;
    set_row_size(MAX_ENTRIES);
    queue_restart();
    for (int k = 0; k < 40; k++) queue_random();
    drain();

    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lrr_pkg.sv
hdl/lrr_link_mem.sv
hdl/lrr_sweep.sv
hdl/linked_row_range_removal_unit.sv
sim/tb.sv
